@@ design/brush_dab_spacer_macros.svh @@
// Assertion macros used by the brush_dab_spacer design file.
`ifndef BRUSH_DAB_SPACER_MACROS_SVH
`define BRUSH_DAB_SPACER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BDS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("brush_dab_spacer: check failed");

// A condition that must hold in the cycle after a trigger.
`define BDS_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("brush_dab_spacer: check failed");

`endif

@@ design/bds_pkg.sv @@
package bds_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int MAX_DABS   = 64;
    localparam int CNT_W      = $clog2(MAX_DABS + 1);
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int RAD_W      = 36;
    localparam int ROOT_STEPS = RAD_W / 2 + FRAC_BITS;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int CARRY_W    = 24;
    localparam int DIST_W     = ROOT_W + 1;
    localparam int SPC_W      = 8 + FRAC_BITS;
    localparam int TOT_W      = DIST_W - FRAC_BITS;
    localparam int T_W        = CARRY_W + 1;
    localparam int PROD_W     = DIFF_W + T_W;
    localparam int DVD_W      = 48;
    localparam int DVS_W      = ROOT_W;
    localparam int Q_W        = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_MOVE    = 2'd1,
        ACT_RELEASE = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRESS,
        ST_SQX,
        ST_SQY,
        ST_ROOT_GO,
        ST_ROOT_WT,
        ST_DIST,
        ST_TOT_GO,
        ST_TOT_WT,
        ST_MUL_I,
        ST_DIV_I_GO,
        ST_DIV_I_WT,
        ST_MUL_S,
        ST_DIV_S_GO,
        ST_DIV_S_WT,
        ST_DAB
    } state_t;

endpackage

@@ design/brush_dab_spacer.sv @@
// Brush dab spacer. Pointer events come in as words on s_axis, brush dab
// positions leave on m_axis. A press gives one dab at the pointer. A move on
// an active drag squares the deltas, takes a bit-serial square root and runs
// a shared bit-serial divider five times (for the dab count and for the start
// offset and step of each axis) before its first dab. A move that gives no
// dab ends after the root and the first divider run. The dabs then leave at
// one per cycle, at most 64 per move, while the output side takes them. The
// block takes one event at a time; the last dab may still wait in the output
// register when the next event is taken. Spacing is to be written on the cfg
// port only while the block is idle; the block itself does not enforce this.
// A spacing of zero acts as one.
`include "brush_dab_spacer_macros.svh"

module brush_dab_spacer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [7:0]                      cfg_data,      // dab_spacing
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x[15:0], pos_y[31:16], left_button[32], layer_visible[33], zero fill
    input  logic [bds_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,  // action
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // dab_x[15:0], dab_y[31:16]
    output logic [bds_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tuser,  // overflow
    output logic                            m_axis_tlast   // last_dab
);
    import bds_pkg::*;

    state_t state_reg, state_next;

    logic [7:0]                spacing_reg;
    logic                      drag_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg;
    logic [CARRY_W-1:0]        carry_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [SQ_W-1:0]           d2_reg;
    logic [ROOT_W-1:0]         len_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic signed [T_W-1:0]     t1_reg;
    logic [CNT_W-1:0]          count_reg, kcnt_reg;
    logic                      ovf_reg, axis_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [Q_W-1:0]     qx_reg, qy_reg, q0x_reg, q0y_reg;
    logic [DVS_W-1:0]          rx_reg, ry_reg, r0x_reg, r0y_reg;
    logic                      out_valid_reg, out_last_reg, out_ovf_reg;
    logic [COORD_W-1:0]        out_x_reg, out_y_reg;

    logic                      s_acc, out_free;
    action_t                   act;
    logic signed [COORD_W-1:0] in_x, in_y;
    logic                      in_left, in_vis;
    logic [7:0]                spc_eff;
    logic [SPC_W-1:0]          sq;
    logic signed [DIFF_W-1:0]  sel_d;
    logic [PROD_W-1:0]         prod_abs;
    logic                      root_start, div_start, div_tot;
    logic                      root_done, div_done;
    logic [ROOT_W-1:0]         root_val;
    logic [DVD_W-1:0]          dvd_in, div_q;
    logic [DVS_W-1:0]          dvs_in, div_r;
    logic [TOT_W-1:0]          total;
    logic                      tot_ovf;
    logic signed [Q_W-1:0]     qu, q_f;
    logic [DVS_W-1:0]          r_f;
    logic                      neg, rnz, dab_last;
    logic [DVS_W:0]            rsum_x, rsum_y;
    logic                      wrap_x, wrap_y;
    logic signed [Q_W-1:0]     tr_x, tr_y;

    assign act     = action_t'(s_axis_tuser);
    assign in_x    = s_axis_tdata[15:0];
    assign in_y    = s_axis_tdata[31:16];
    assign in_left = s_axis_tdata[32];
    assign in_vis  = s_axis_tdata[33];

    assign cfg_ready = 1'b1;
    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign spc_eff   = (spacing_reg == 8'd0) ? 8'd1 : spacing_reg;
    assign sq        = {spc_eff, {FRAC_BITS{1'b0}}};
    assign sel_d     = axis_reg ? dy_reg : dx_reg;
    assign prod_abs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign dvd_in    = div_tot ? DVD_W'(dist_reg) : DVD_W'(prod_abs);
    assign dvs_in    = div_tot ? DVS_W'(sq) : len_reg;
    assign total     = div_q[TOT_W-1:0];
    assign tot_ovf   = total > TOT_W'(MAX_DABS);
    assign dab_last  = (kcnt_reg == count_reg);

    // Turn the magnitude quotient into a floor quotient with a remainder in [0, len).
    assign neg = prod_reg[PROD_W-1];
    assign qu  = div_q[Q_W-1:0];
    assign rnz = (div_r != '0);
    assign q_f = neg ? (-qu - Q_W'(rnz)) : qu;
    assign r_f = (neg && rnz) ? DVS_W'(len_reg - div_r) : div_r;

    // Stepping one dab along: add the per-dab quotient and remainder.
    assign rsum_x = {1'b0, rx_reg} + {1'b0, r0x_reg};
    assign rsum_y = {1'b0, ry_reg} + {1'b0, r0y_reg};
    assign wrap_x = (len_reg != '0) && (rsum_x >= {1'b0, len_reg});
    assign wrap_y = (len_reg != '0) && (rsum_y >= {1'b0, len_reg});

    // Floor to truncation: a negative quotient with a remainder rounds up.
    assign tr_x = qx_reg + Q_W'(qx_reg[Q_W-1] && (rx_reg != '0));
    assign tr_y = qy_reg + Q_W'(qy_reg[Q_W-1] && (ry_reg != '0));

    bds_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (d2_reg),
        .done     (root_done),
        .root     (root_val)
    );

    bds_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dvd_in),
        .divisor   (dvs_in),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (act == ACT_PRESS && in_left && in_vis)
                        state_next = ST_PRESS;
                    else if (act == ACT_MOVE && drag_reg && in_vis)
                        state_next = ST_SQX;
                end
            end
            ST_PRESS:    if (out_free) state_next = ST_IDLE;
            ST_SQX:      state_next = ST_SQY;
            ST_SQY:      state_next = ST_ROOT_GO;
            ST_ROOT_GO:  state_next = ST_ROOT_WT;
            ST_ROOT_WT:  if (root_done) state_next = ST_DIST;
            ST_DIST:     state_next = ST_TOT_GO;
            ST_TOT_GO:   state_next = ST_TOT_WT;
            ST_TOT_WT:
            begin
                if (div_done)
                begin
                    if (total == '0)
                        state_next = ST_IDLE;
                    else if (len_reg == '0)
                        state_next = ST_DAB;
                    else
                        state_next = ST_MUL_I;
                end
            end
            ST_MUL_I:    state_next = ST_DIV_I_GO;
            ST_DIV_I_GO: state_next = ST_DIV_I_WT;
            ST_DIV_I_WT: if (div_done) state_next = ST_MUL_S;
            ST_MUL_S:    state_next = ST_DIV_S_GO;
            ST_DIV_S_GO: state_next = ST_DIV_S_WT;
            ST_DIV_S_WT:
            begin
                if (div_done)
                    state_next = axis_reg ? ST_DAB : ST_MUL_I;
            end
            ST_DAB:      if (out_free && dab_last) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        root_start    = 1'b0;
        div_start     = 1'b0;
        div_tot       = 1'b0;
        unique case (state_reg)
            ST_IDLE:     s_axis_tready = 1'b1;
            ST_ROOT_GO:  root_start = 1'b1;
            ST_TOT_GO:
            begin
                div_start = 1'b1;
                div_tot   = 1'b1;
            end
            ST_DIV_I_GO: div_start = 1'b1;
            ST_DIV_S_GO: div_start = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spacing_reg   <= 8'd1;
            drag_reg      <= 1'b0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            carry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                spacing_reg <= cfg_data;
            if (state_reg == ST_IDLE && s_acc)
            begin
                if (act == ACT_PRESS && in_left && in_vis)
                begin
                    drag_reg  <= 1'b1;
                    ax_reg    <= in_x;
                    ay_reg    <= in_y;
                    carry_reg <= '0;
                end
                else if (act == ACT_RELEASE && in_left)
                    drag_reg <= 1'b0;
            end
            if (state_reg == ST_TOT_WT && div_done)
            begin
                if (total == '0)
                begin
                    carry_reg <= dist_reg[CARRY_W-1:0];
                    ax_reg    <= px_reg;
                    ay_reg    <= py_reg;
                end
                else
                    carry_reg <= CARRY_W'(div_r);
            end
            if (state_reg == ST_DAB && out_free && dab_last)
            begin
                ax_reg <= px_reg;
                ay_reg <= py_reg;
            end
            if ((state_reg == ST_PRESS || state_reg == ST_DAB) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                px_reg <= in_x;
                py_reg <= in_y;
                dx_reg <= DIFF_W'(in_x) - DIFF_W'(ax_reg);
                dy_reg <= DIFF_W'(in_y) - DIFF_W'(ay_reg);
            end
            ST_SQX:     d2_reg <= SQ_W'(dx_reg * dx_reg);
            ST_SQY:     d2_reg <= d2_reg + SQ_W'(dy_reg * dy_reg);
            ST_ROOT_WT: len_reg <= root_val;
            ST_DIST:    dist_reg <= DIST_W'(carry_reg) + DIST_W'(len_reg);
            ST_TOT_WT:
            begin
                t1_reg    <= $signed(T_W'(sq)) - $signed(T_W'(carry_reg));
                count_reg <= tot_ovf ? CNT_W'(MAX_DABS) : CNT_W'(total);
                ovf_reg   <= tot_ovf;
                kcnt_reg  <= CNT_W'(1);
                axis_reg  <= 1'b0;
                // A zero-length segment leaves every dab at the anchor.
                qx_reg    <= Q_W'(ax_reg);
                qy_reg    <= Q_W'(ay_reg);
                rx_reg    <= '0;
                ry_reg    <= '0;
                q0x_reg   <= '0;
                q0y_reg   <= '0;
                r0x_reg   <= '0;
                r0y_reg   <= '0;
            end
            ST_MUL_I:   prod_reg <= PROD_W'(sel_d * t1_reg);
            ST_MUL_S:   prod_reg <= PROD_W'(sel_d * $signed({1'b0, sq}));
            ST_DIV_I_WT:
            begin
                if (div_done)
                begin
                    if (axis_reg)
                    begin
                        qy_reg <= Q_W'(ay_reg) + q_f;
                        ry_reg <= r_f;
                    end
                    else
                    begin
                        qx_reg <= Q_W'(ax_reg) + q_f;
                        rx_reg <= r_f;
                    end
                end
            end
            ST_DIV_S_WT:
            begin
                if (div_done)
                begin
                    if (axis_reg)
                    begin
                        q0y_reg <= q_f;
                        r0y_reg <= r_f;
                    end
                    else
                    begin
                        q0x_reg <= q_f;
                        r0x_reg <= r_f;
                    end
                    axis_reg <= 1'b1;
                end
            end
            ST_DAB:
            begin
                if (out_free)
                begin
                    kcnt_reg <= kcnt_reg + 1'b1;
                    qx_reg   <= qx_reg + q0x_reg + Q_W'(wrap_x);
                    qy_reg   <= qy_reg + q0y_reg + Q_W'(wrap_y);
                    rx_reg   <= wrap_x ? DVS_W'(rsum_x - {1'b0, len_reg}) : DVS_W'(rsum_x);
                    ry_reg   <= wrap_y ? DVS_W'(rsum_y - {1'b0, len_reg}) : DVS_W'(rsum_y);
                end
            end
            default: ;
        endcase

        if (out_free)
        begin
            if (state_reg == ST_PRESS)
            begin
                out_x_reg    <= px_reg;
                out_y_reg    <= py_reg;
                out_last_reg <= 1'b1;
                out_ovf_reg  <= 1'b0;
            end
            else if (state_reg == ST_DAB)
            begin
                out_x_reg    <= tr_x[COORD_W-1:0];
                out_y_reg    <= tr_y[COORD_W-1:0];
                out_last_reg <= dab_last;
                out_ovf_reg  <= ovf_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    `BDS_ASSERT_ALWAYS(a_dab_count_range, (state_reg != ST_DAB) || (kcnt_reg != '0 && kcnt_reg <= count_reg))
    `BDS_ASSERT_ALWAYS(a_rem_below_len, (state_reg != ST_DAB) || (len_reg == '0) || (rx_reg < len_reg && ry_reg < len_reg))
    `BDS_ASSERT_ALWAYS(a_more_dabs_follow, !(m_axis_tvalid && !m_axis_tlast) || (state_reg == ST_DAB))
    `BDS_ASSERT_NEXT(a_last_dab_frees, (state_reg == ST_DAB && out_free && dab_last), (state_reg == ST_IDLE && m_axis_tlast))

endmodule

@@ design/bds_root.sv @@
module bds_root (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bds_pkg::SQ_W-1:0]    radicand,
    output logic                        done,
    output logic [bds_pkg::ROOT_W-1:0]  root
);
    import bds_pkg::*;

    localparam int CW = $clog2(ROOT_STEPS + 1);

    logic [RAD_W-1:0]    vsh_reg, vsh_next;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [ROOT_W+2:0]   remx;
    logic [ROOT_W+2:0]   trial;

    // One result bit per cycle: bring down two radicand bits, try 4*root+1.
    always_comb
    begin
        remx      = {rem_reg, vsh_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        vsh_next  = vsh_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            vsh_next  = RAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(ROOT_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            vsh_next = {vsh_reg[RAD_W-3:0], 2'b00};
            if (remx >= trial)
            begin
                rem_next  = (ROOT_W+1)'(remx - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (ROOT_W+1)'(remx);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vsh_reg  <= vsh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ design/bds_div.sv @@
module bds_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bds_pkg::DVD_W-1:0]  dividend,
    input  logic [bds_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [bds_pkg::DVD_W-1:0]  quotient,
    output logic [bds_pkg::DVS_W-1:0]  remainder
);
    import bds_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;

    // Restoring division, one quotient bit per cycle shifted in at the bottom.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = CW'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule
